FILE: sv/abd_pkg.sv
// Shared types, codes and coefficient tables of the ADPCM block decoder.
package abd_pkg;

  localparam int unsigned BLOCK_WORDS_C = 8;
  localparam int unsigned COUNT_W = $clog2(BLOCK_WORDS_C);

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [15:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_HEADER = 2'd1,
    CMD_DATA   = 2'd2
  } cmd_t;

  typedef enum logic {
    OP_CLEAR = 1'b0,
    OP_DATA  = 1'b1
  } op_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] word;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
    logic               block_end;
    logic               loop_end;
    logic               stop_envelope;
  } out_item_t;

  // One queued job for the decode side, header already resolved.
  typedef struct packed {
    op_t         op;
    logic [15:0] word;
    logic [3:0]  shift;
    logic [2:0]  filter;
    logic        loop_end;
    logic        loop_repeat;
    logic        block_end;
  } job_t;

  function automatic logic signed [7:0] coef_first(input logic [2:0] filter);
    logic signed [7:0] c;
    unique case (filter)
      3'd1:    c = 8'sd60;
      3'd2:    c = 8'sd115;
      3'd3:    c = 8'sd98;
      3'd4:    c = 8'sd122;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [7:0] coef_second(input logic [2:0] filter);
    logic signed [7:0] c;
    unique case (filter)
      3'd2:    c = -8'sd52;
      3'd3:    c = -8'sd55;
      3'd4:    c = -8'sd60;
      default: c = 8'sd0;
    endcase
    return c;
  endfunction

endpackage

FILE: sv/abd_front.sv
// Front end: accepts items, latches headers, tracks the block position, queues jobs.
module abd_front
  import abd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_data,
  input  logic     queue_full,
  output logic     in_stall,
  output logic     push,
  output job_t     push_job
);

  logic [3:0]         shift_r;
  logic [2:0]         filter_r;
  logic               loop_end_r;
  logic               loop_repeat_r;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_inc;
  logic               accept;
  logic               is_start;
  logic               is_header;
  logic               is_data;
  logic               end_of_block;

  assign in_stall  = queue_full;
  assign accept    = in_valid && !queue_full;
  assign is_start  = in_data.command == CMD_START;
  assign is_header = in_data.command == CMD_HEADER;
  assign is_data   = in_data.command == CMD_DATA;

  assign count_inc    = count_r + COUNT_W'(1);
  assign end_of_block = count_inc >= COUNT_W'(BLOCK_WORDS_C - 1);

  // Headers are absorbed here; start and data words go to the decode side.
  assign push = accept && (is_start || is_data);

  always_comb begin
    push_job.op          = is_data ? OP_DATA : OP_CLEAR;
    push_job.word        = in_data.word;
    push_job.shift       = shift_r;
    push_job.filter      = filter_r;
    push_job.loop_end    = loop_end_r;
    push_job.loop_repeat = loop_repeat_r;
    push_job.block_end   = end_of_block;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r       <= '0;
      filter_r      <= '0;
      loop_end_r    <= 1'b0;
      loop_repeat_r <= 1'b0;
      count_r       <= '0;
    end else if (accept) begin
      priority if (is_start) begin
        count_r <= '0;
      end else if (is_header) begin
        shift_r       <= in_data.word[3:0];
        filter_r      <= in_data.word[6:4];
        loop_end_r    <= in_data.word[8];
        loop_repeat_r <= in_data.word[9];
        count_r       <= '0;
      end else if (is_data) begin
        count_r <= end_of_block ? '0 : count_inc;
      end else begin
        // unused command: hold everything
        count_r <= count_r;
      end
    end
  end

endmodule

FILE: sv/abd_queue.sv
// Short job queue between the front end and the decode side.
module abd_queue
  import abd_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output job_t head_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign full       = count_r == CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head_job   = slots_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

FILE: sv/abd_back.sv
// Decode: one nibble prediction per unstalled cycle into a registered output.
module abd_back
  import abd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic               out_valid_r;
  out_item_t          out_data_r;
  logic [1:0]         idx_r;
  logic signed [15:0] hist_one_r;
  logic signed [15:0] hist_two_r;

  logic               step;
  logic               fourth;
  logic [3:0]         nib;
  logic signed [15:0] base;
  logic signed [7:0]  c_one;
  logic signed [7:0]  c_two;
  logic signed [23:0] prod_one;
  logic signed [23:0] prod_two;
  logic signed [23:0] term_one;
  logic signed [23:0] term_two;
  logic signed [18:0] sum;
  logic signed [15:0] sample;
  out_item_t          result;

  assign step   = head_valid && (!out_valid_r || !out_stall);
  assign fourth = idx_r == 2'd3;
  assign pop    = step && ((head_job.op == OP_CLEAR) || fourth);

  assign nib      = head_job.word[{idx_r, 2'b00} +: 4];
  assign base     = $signed({nib, 12'h000}) >>> head_job.shift;
  assign c_one    = coef_first(head_job.filter);
  assign c_two    = coef_second(head_job.filter);
  assign prod_one = c_one * hist_one_r;
  assign prod_two = c_two * hist_two_r;
  assign term_one = prod_one >>> 6;
  assign term_two = prod_two >>> 6;
  assign sum      = 19'(base) + 19'(term_one) + 19'(term_two);

  always_comb begin
    if (sum > 19'(SAMPLE_MAX)) begin
      sample = SAMPLE_MAX;
    end else if (sum < 19'(SAMPLE_MIN)) begin
      sample = SAMPLE_MIN;
    end else begin
      sample = sum[15:0];
    end
    result.sample        = sample;
    result.last          = fourth;
    result.block_end     = fourth && head_job.block_end;
    result.loop_end      = result.block_end && head_job.loop_end;
    result.stop_envelope = result.loop_end && !head_job.loop_repeat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
      hist_one_r  <= '0;
      hist_two_r  <= '0;
    end else begin
      if (step && (head_job.op == OP_DATA)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (step) begin
        if (head_job.op == OP_CLEAR) begin
          hist_one_r <= '0;
          hist_two_r <= '0;
        end else begin
          hist_two_r <= hist_one_r;
          hist_one_r <= sample;
          idx_r      <= idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step && (head_job.op == OP_DATA)) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: sv/adpcm_block_decoder.sv
// ADPCM block decoder top level: front end, job queue and decode side.
// With the queue empty and the output free, a data word is written into a queue slot
// when accepted, then its first sample is computed into the output register.
// A data word yields four samples, one per cycle from the predictor loop while the
// output is free; a start only clears history; a header never reaches the decoder.
// Input is taken while the job queue has room; output is held in one register.
// Synchronous active-low reset clears history, header, word count and the queue.
module adpcm_block_decoder
  import abd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  logic queue_full;
  logic push;
  job_t push_job;
  logic pop;
  logic head_valid;
  job_t head_job;

  abd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_data    (in_data),
    .queue_full (queue_full),
    .in_stall   (in_stall),
    .push       (push),
    .push_job   (push_job)
  );

  abd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  abd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

FILE: test/adpcm_block_decoder_test.sv
// Self-checking testbench for the ADPCM block decoder: random blocks, stalls, sample check.
`timescale 1ns / 100ps

module adpcm_block_decoder_test;
  import abd_pkg::*;

  localparam int ITEM_TARGET = 420;
  localparam int MAX_PRINTED = 40;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // decoder state as seen by the predictor
  logic signed [15:0] hist_one = '0;
  logic signed [15:0] hist_two = '0;
  logic [3:0]         shift_amt = '0;
  logic [2:0]         filt = '0;
  logic               loop_end_flag = 1'b0;
  logic               loop_repeat_flag = 1'b0;
  logic [2:0]         data_count = '0;

  in_item_t  items_to_send[$];
  out_item_t expected_samples[$];
  int        mismatch_count = 0;

  int        burst_left = 8;
  int        gap_left = 0;
  int        stall_mode = 0;
  int        mode_left = 40;
  int        cycle_count = 0;
  logic      long_hold;
  logic      next_stall;

  adpcm_block_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int first_tap(logic [2:0] f);
    case (f)
      3'd1:    return 60;
      3'd2:    return 115;
      3'd3:    return 98;
      3'd4:    return 122;
      default: return 0;
    endcase
  endfunction

  function automatic int second_tap(logic [2:0] f);
    case (f)
      3'd2:    return -52;
      3'd3:    return -55;
      3'd4:    return -60;
      default: return 0;
    endcase
  endfunction

  // Advance the predictor by one accepted item and queue the samples it yields.
  function automatic void decode_item(in_item_t item);
    out_item_t         res;
    logic signed [3:0] nib;
    int                acc;
    logic              block_done;
    case (cmd_t'(item.command))
      CMD_START: begin
        hist_one = '0;
        hist_two = '0;
        data_count = '0;
      end
      CMD_HEADER: begin
        shift_amt = item.word[3:0];
        filt = item.word[6:4];
        loop_end_flag = item.word[8];
        loop_repeat_flag = item.word[9];
        data_count = '0;
      end
      CMD_DATA: begin
        block_done = (data_count == 3'd6);
        for (int i = 0; i < 4; i++) begin
          nib = item.word[4*i +: 4];
          acc = int'(nib) * 4096;
          acc = acc >>> shift_amt;
          acc = acc + ((first_tap(filt) * int'(hist_one)) >>> 6)
                    + ((second_tap(filt) * int'(hist_two)) >>> 6);
          if (acc > 32767) acc = 32767;
          if (acc < -32768) acc = -32768;
          hist_two = hist_one;
          hist_one = acc[15:0];
          res.sample = acc[15:0];
          res.last = (i == 3);
          res.block_end = (i == 3) && block_done;
          res.loop_end = res.block_end && loop_end_flag;
          res.stop_envelope = res.loop_end && !loop_repeat_flag;
          expected_samples.push_back(res);
        end
        data_count = block_done ? 3'd0 : data_count + 3'd1;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_PRINTED) $display("%0t: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_sample(out_item_t got);
    out_item_t want;
    if (expected_samples.size() == 0) begin
      report_mismatch($sformatf("unexpected sample %0d", got.sample));
    end else begin
      want = expected_samples.pop_front();
      if (got.sample !== want.sample)
        report_mismatch($sformatf("sample %0d, want %0d", got.sample, want.sample));
      if (got.last !== want.last)
        report_mismatch($sformatf("last %b, want %b", got.last, want.last));
      if (got.block_end !== want.block_end)
        report_mismatch($sformatf("block_end %b, want %b", got.block_end, want.block_end));
      if (got.loop_end !== want.loop_end)
        report_mismatch($sformatf("loop_end %b, want %b", got.loop_end, want.loop_end));
      if (got.stop_envelope !== want.stop_envelope)
        report_mismatch($sformatf("stop_envelope %b, want %b",
                                  got.stop_envelope, want.stop_envelope));
    end
  endtask

  function automatic void push_item(cmd_t c, logic [15:0] w);
    in_item_t it;
    it.command = c;
    it.word = w;
    items_to_send.push_back(it);
  endfunction

  // Mostly uniform nibbles; now and then a run of extreme nibbles to drive the clamp.
  function automatic logic [15:0] random_data_word();
    case ($urandom_range(0, 9))
      0:       return 16'h7777;
      1:       return 16'h8888;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void push_block(logic [15:0] hdr, int n_data);
    push_item(CMD_HEADER, hdr);
    for (int i = 0; i < n_data; i++) push_item(CMD_DATA, random_data_word());
  endfunction

  // Sender: bursts of items separated by idle gaps; hold a stalled item unchanged.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) decode_item(in_data);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (items_to_send.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= items_to_send.pop_front();
          burst_left = burst_left - 1;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) cycle_count <= 0;
    else cycle_count <= cycle_count + 1;
  end

  // Long receiver hold-offs so the block fills up and stalls its input.
  assign long_hold = (cycle_count >= 600 && cycle_count < 900) ||
                     (cycle_count >= 2500 && cycle_count < 2700);

  // Receiver: check accepted samples, stall on a changing pattern.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_sample(out_data);
      case (stall_mode)
        0:       next_stall = 1'b0;
        1:       next_stall = $urandom_range(0, 1);
        2:       next_stall = ($urandom_range(0, 4) != 0);
        default: next_stall = (mode_left % 3 == 0);
      endcase
      mode_left = mode_left - 1;
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      out_stall <= long_hold || next_stall;
    end
  end

  initial begin
    int pick;
    // directed: extremes, filters zero, two, four and an unused filter code, loop flag combinations
    push_item(CMD_START, 16'h0000);
    push_item(CMD_HEADER, 16'h0000);
    push_item(CMD_DATA, 16'h7777);
    push_item(CMD_DATA, 16'h8888);
    // filter four, loop end without repeat, ignored header bits set
    push_item(CMD_HEADER, 16'hFDC0);
    push_item(CMD_DATA, 16'h7777);
    push_item(CMD_DATA, 16'h7777);
    push_item(CMD_DATA, 16'h7777);
    push_item(CMD_DATA, 16'h8888);
    push_item(CMD_DATA, 16'h8888);
    push_item(CMD_DATA, 16'hFFFF);
    push_item(CMD_DATA, 16'h0000);
    // shift thirteen, loop end with repeat
    push_item(CMD_HEADER, 16'h030D);
    push_item(CMD_DATA, 16'h8000);
    push_item(CMD_DATA, 16'h0008);
    push_item(CMD_DATA, 16'h7F80);
    push_item(CMD_DATA, 16'h1111);
    push_item(CMD_DATA, 16'hEEEE);
    push_item(CMD_DATA, 16'h4321);
    push_item(CMD_DATA, 16'hABCD);
    // data after block end with no new header: count wraps, header kept
    push_item(CMD_DATA, 16'h1234);
    push_item(CMD_HEADER, 16'h002E);
    push_item(CMD_DATA, 16'hF0F0);
    push_item(CMD_HEADER, 16'h007F);
    push_item(CMD_DATA, 16'hFEDC);
    push_item(CMD_START, 16'hFFFF);

    while (items_to_send.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        if ($urandom_range(0, 3) == 0) push_item(CMD_START, 16'($urandom));
        push_block(16'($urandom), 7);
      end else if (pick < 90) begin
        push_block(16'($urandom), $urandom_range(1, 6));
      end else begin
        repeat ($urandom_range(1, 4))
          push_item(cmd_t'($urandom_range(0, 2)), 16'($urandom));
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (items_to_send.size() != 0 || in_valid) @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("adpcm_block_decoder_test: PASS");
    end else begin
      $display("adpcm_block_decoder_test: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("%0t: timeout, %0d samples outstanding", $time, expected_samples.size());
    $display("adpcm_block_decoder_test: FAIL");
    $finish;
  end

endmodule
